/* rtl/ugot_pkg.sv */
package ugot_pkg;

   localparam int MAX_COLUMNS   = 64;
   localparam int MAX_ROWS      = 64;
   localparam int MAX_SLOTS     = 256;
   localparam int CELL_CAP      = MAX_COLUMNS * MAX_ROWS;
   localparam int CELL_W        = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
   localparam int TOT_W         = $clog2(CELL_CAP + 1);
   localparam int CX_W          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CY_W          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SLOT_W        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int OCC_W         = 9;
   localparam int FALLBACK_CELL = 64;
   localparam int NUM_W         = 17;
   localparam int DEN_W         = 16;
   localparam int DIM_W         = 7;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_ORIGIN_X  = 3'd0;
   localparam csr_idx_type CSR_ORIGIN_Y  = 3'd1;
   localparam csr_idx_type CSR_LIMIT_X   = 3'd2;
   localparam csr_idx_type CSR_LIMIT_Y   = 3'd3;
   localparam csr_idx_type CSR_CELL_SIZE = 3'd4;
   localparam csr_idx_type CSR_COLUMNS   = 3'd5;
   localparam csr_idx_type CSR_ROWS      = 3'd6;

   localparam logic [2:0] ACT_UPDATE      = 3'd0;
   localparam logic [2:0] ACT_REMOVE      = 3'd1;
   localparam logic [2:0] ACT_CLEAR_DIRTY = 3'd2;
   localparam logic [2:0] ACT_CLEAR_ALL   = 3'd3;
   localparam logic [2:0] ACT_READ_DIRTY  = 3'd4;

   typedef struct packed {
      logic [CX_W-1:0] x0;
      logic [CX_W-1:0] x1;
      logic [CY_W-1:0] y0;
      logic [CY_W-1:0] y1;
   } span_type;

endpackage

/* rtl/ugot_if.sv */
interface ugot_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [7:0]         entry_slot;
   logic               present;
   logic signed [15:0] min_x;
   logic signed [15:0] min_y;
   logic signed [15:0] max_x;
   logic signed [15:0] max_y;
   logic [11:0]        read_index;

   modport source (output valid, action, entry_slot, present, min_x, min_y, max_x, max_y,
                   read_index, input ready);
   modport sink (input valid, action, entry_slot, present, min_x, min_y, max_x, max_y,
                 read_index, output ready);
endinterface

interface ugot_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        entry_active;
   logic        read_valid;
   logic [5:0]  cell_x;
   logic [5:0]  cell_y;
   logic [12:0] dirty_count;

   modport source (output valid, status, entry_active, read_valid, cell_x, cell_y,
                   dirty_count, input ready);
   modport sink (input valid, status, entry_active, read_valid, cell_x, cell_y,
                 dirty_count, output ready);
endinterface

/* rtl/uniform_grid_occupancy_tracker_core.sv */
// Uniform grid occupancy tracker: one word in, one word out, one item at a time.
// Cell counts, dirty flags, the dirty list and entry spans live in synchronous
// memories with one write and one read address each. An update inside the
// limits makes four divisions by the cell size; if the span changed, it walks
// the old span, if any, twice (decrement, then mark dirty) and the new span
// once, cell by cell, with a read-modify-write per cell. A remove walks the
// old span twice, a clear dirty walks the dirty list, a read dirty makes one
// division by the column count, and a clear all sweeps the cell memories.
// After reset the same sweep runs before the first word is taken; configuration
// writes are taken at any time and must only be made while the block is idle.
module uniform_grid_occupancy_tracker_core (
   input  logic                  clock,
   input  logic                  reset,
   ugot_req_if.sink              req_chan,
   ugot_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  ugot_pkg::csr_idx_type csr_index,
   input  logic [ugot_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ugot_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV_LOAD, S_DIV, S_DIV_DONE, S_LOOKUP, S_DECIDE,
      S_W_START, S_W_RD, S_W_WR, S_W_END, S_CD_RD, S_CD_WR, S_RL_WAIT, S_FINISH
   } state_type;

   typedef enum logic [1:0] {PH_DEC, PH_MARK, PH_LINK} phase_type;

   // configuration
   logic signed [15:0] origin_x_ff, origin_y_ff, limit_x_ff, limit_y_ff;
   logic [15:0]        cell_size_ff;
   logic [DIM_W-1:0]   columns_ff, rows_ff;

   // control
   state_type            state_ff;
   phase_type            phase_ff;
   logic [2:0]           act_ff;
   logic [7:0]           slot_ff;
   logic                 slot_ok_ff;
   logic signed [15:0]   min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [11:0]          ridx_ff;
   logic                 status_ff, rvalid_ff, link_pend_ff, clr_reply_ff;
   logic [5:0]           cx_ff, cy_ff;
   logic [1:0]           k_ff;
   span_type             nsp_ff, wsp_ff;
   logic [CX_W-1:0]      wx_ff;
   logic [CY_W-1:0]      wy_ff;
   logic [CELL_W-1:0]    cd_idx_ff, clr_idx_ff;
   logic [TOT_W-1:0]     total_ff;
   logic [MAX_SLOTS-1:0] active_ff;
   logic [NUM_W-1:0]     div_num_ff;
   logic [DEN_W-1:0]     div_rem_ff, div_den_ff;
   logic [4:0]           div_cnt_ff;

   // result register
   logic        rsp_valid_ff, rsp_status_ff, rsp_active_ff, rsp_rvalid_ff;
   logic [5:0]  rsp_cx_ff, rsp_cy_ff;
   logic [12:0] rsp_count_ff;
   logic        rsp_load;

   // memories
   logic [OCC_W-1:0]  occ_mem  [CELL_CAP];
   logic              flag_mem [CELL_CAP];
   logic [CELL_W-1:0] list_mem [CELL_CAP];
   span_type          span_mem [MAX_SLOTS];

   logic [OCC_W-1:0]  occ_rd_ff;
   logic              flag_rd_ff;
   logic [CELL_W-1:0] list_rd_ff;
   span_type          span_rd_ff;

   logic              occ_we, flag_we, flag_wd, list_we, span_we;
   logic [CELL_W-1:0] occ_wa, flag_wa, cell_addr, list_ra;
   logic [OCC_W-1:0]  occ_wd;

   logic [DIM_W-1:0]   nc_eff, nr_eff, lim, lim_m1;
   logic               enabled, slot_ok_in, hit_in, cur_active, changed, mark_ok;
   logic               link_go, last_x, last_y, span_empty;
   logic [DEN_W-1:0]   cs_eff;
   logic signed [15:0] pos_sel, org_sel;
   logic signed [16:0] diff;
   logic [NUM_W-1:0]   num_sel, clamp_q;
   logic [DEN_W-1:0]   den_sel;
   logic [NUM_W-1:0]   div_trial, div_sub;
   logic               div_ge;
   logic [SLOT_W-1:0]  slot_idx;

   assign nc_eff  = (int'(columns_ff) > MAX_COLUMNS) ? DIM_W'(MAX_COLUMNS) : columns_ff;
   assign nr_eff  = (int'(rows_ff) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign enabled = (nc_eff != '0) && (nr_eff != '0);
   assign cs_eff  = (cell_size_ff < 16'd2) ? DEN_W'(FALLBACK_CELL) : cell_size_ff;

   assign slot_ok_in = int'(req_chan.entry_slot) < MAX_SLOTS;
   assign hit_in = req_chan.present && (req_chan.min_x <= limit_x_ff) &&
                   (req_chan.max_x >= origin_x_ff) && (req_chan.min_y <= limit_y_ff) &&
                   (req_chan.max_y >= origin_y_ff);

   assign slot_idx   = SLOT_W'(slot_ff);
   assign cur_active = active_ff[slot_idx];
   assign changed    = !cur_active || (span_rd_ff != nsp_ff);

   always_comb begin
      case (k_ff)
         2'd0:    pos_sel = min_x_ff;
         2'd1:    pos_sel = max_x_ff;
         2'd2:    pos_sel = min_y_ff;
         default: pos_sel = max_y_ff;
      endcase
   end

   assign org_sel = k_ff[1] ? origin_y_ff : origin_x_ff;
   assign diff    = {pos_sel[15], pos_sel} - {org_sel[15], org_sel};
   assign num_sel = (act_ff == ACT_READ_DIRTY) ? NUM_W'(list_rd_ff) :
                    (diff[16] ? '0 : NUM_W'(diff));
   assign den_sel = (act_ff == ACT_READ_DIRTY) ? DEN_W'(nc_eff) : cs_eff;

   assign div_trial = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign div_ge    = div_trial >= NUM_W'(div_den_ff);
   assign div_sub   = div_trial - NUM_W'(div_den_ff);

   assign lim     = k_ff[1] ? nr_eff : nc_eff;
   assign lim_m1  = lim - DIM_W'(1);
   assign clamp_q = (div_num_ff > NUM_W'(lim_m1)) ? NUM_W'(lim_m1) : div_num_ff;

   assign cell_addr  = CELL_W'(wy_ff) * CELL_W'(nc_eff) + CELL_W'(wx_ff);
   assign last_x     = wx_ff == wsp_ff.x1;
   assign last_y     = wy_ff == wsp_ff.y1;
   assign span_empty = (wsp_ff.x0 > wsp_ff.x1) || (wsp_ff.y0 > wsp_ff.y1);
   assign mark_ok    = (phase_ff != PH_DEC) && !flag_rd_ff &&
                       (total_ff < TOT_W'(CELL_CAP));
   assign list_ra    = (act_ff == ACT_READ_DIRTY) ? CELL_W'(ridx_ff) : cd_idx_ff;

   assign link_go = link_pend_ff &&
                    (((state_ff == S_DECIDE) && !cur_active) ||
                     ((state_ff == S_W_END) && (phase_ff == PH_MARK)));

   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      occ_we  = 1'b0;
      occ_wa  = cell_addr;
      occ_wd  = '0;
      flag_we = 1'b0;
      flag_wa = cell_addr;
      flag_wd = 1'b0;
      list_we = 1'b0;
      span_we = link_go;
      case (state_ff)
         S_CLEAR: begin
            occ_we  = 1'b1;
            occ_wa  = clr_idx_ff;
            flag_we = 1'b1;
            flag_wa = clr_idx_ff;
         end
         S_W_WR: begin
            if (phase_ff == PH_DEC) begin
               occ_we = 1'b1;
               occ_wd = occ_rd_ff - OCC_W'(occ_rd_ff != '0);
            end else if (phase_ff == PH_LINK) begin
               occ_we = 1'b1;
               occ_wd = occ_rd_ff + OCC_W'(occ_rd_ff != '1);
            end
            flag_we = mark_ok;
            flag_wd = 1'b1;
            list_we = mark_ok;
         end
         S_CD_WR: begin
            flag_we = 1'b1;
            flag_wa = list_rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_wa] <= occ_wd;
      occ_rd_ff <= occ_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      flag_rd_ff <= flag_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (list_we) list_mem[CELL_W'(total_ff)] <= cell_addr;
      list_rd_ff <= list_mem[list_ra];
   end

   always_ff @(posedge clock) begin
      if (span_we) span_mem[slot_idx] <= nsp_ff;
      span_rd_ff <= span_mem[slot_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         limit_x_ff   <= '0;
         limit_y_ff   <= '0;
         cell_size_ff <= 16'd64;
         columns_ff   <= '0;
         rows_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata;
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata;
            CSR_LIMIT_X:   limit_x_ff   <= csr_wdata;
            CSR_LIMIT_Y:   limit_y_ff   <= csr_wdata;
            CSR_CELL_SIZE: cell_size_ff <= csr_wdata;
            CSR_COLUMNS:   columns_ff   <= csr_wdata[DIM_W-1:0];
            CSR_ROWS:      rows_ff      <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         clr_reply_ff <= 1'b0;
         total_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + CELL_W'(1);
               if (clr_idx_ff == CELL_W'(CELL_CAP - 1))
                  state_ff <= clr_reply_ff ? S_FINISH : S_IDLE;
            end
            S_IDLE: begin
               if (req_chan.valid) begin
                  act_ff     <= req_chan.action;
                  slot_ff    <= req_chan.entry_slot;
                  slot_ok_ff <= slot_ok_in;
                  min_x_ff   <= req_chan.min_x;
                  min_y_ff   <= req_chan.min_y;
                  max_x_ff   <= req_chan.max_x;
                  max_y_ff   <= req_chan.max_y;
                  ridx_ff    <= req_chan.read_index;
                  status_ff  <= 1'b0;
                  rvalid_ff  <= 1'b0;
                  cx_ff      <= '0;
                  cy_ff      <= '0;
                  k_ff       <= '0;
                  cd_idx_ff  <= '0;
                  state_ff   <= S_FINISH;
                  unique case (req_chan.action)
                     ACT_UPDATE: begin
                        if (!enabled) begin
                           status_ff <= 1'b1;
                        end else if (slot_ok_in) begin
                           link_pend_ff <= hit_in;
                           state_ff     <= hit_in ? S_DIV_LOAD : S_LOOKUP;
                        end
                     end
                     ACT_REMOVE: begin
                        link_pend_ff <= 1'b0;
                        if (slot_ok_in) state_ff <= S_LOOKUP;
                     end
                     ACT_CLEAR_DIRTY: begin
                        if (total_ff != '0) state_ff <= S_CD_RD;
                     end
                     ACT_CLEAR_ALL: begin
                        active_ff    <= '0;
                        total_ff     <= '0;
                        clr_idx_ff   <= '0;
                        clr_reply_ff <= 1'b1;
                        state_ff     <= S_CLEAR;
                     end
                     ACT_READ_DIRTY: begin
                        if (enabled && ({1'b0, req_chan.read_index} < total_ff))
                           state_ff <= S_RL_WAIT;
                     end
                     default: ;
                  endcase
               end
            end
            S_RL_WAIT: state_ff <= S_DIV_LOAD;
            S_DIV_LOAD: begin
               div_num_ff <= num_sel;
               div_den_ff <= den_sel;
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               div_num_ff <= {div_num_ff[NUM_W-2:0], div_ge};
               div_rem_ff <= div_ge ? div_sub[DEN_W-1:0] : div_trial[DEN_W-1:0];
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'(NUM_W - 1)) state_ff <= S_DIV_DONE;
            end
            S_DIV_DONE: begin
               if (act_ff == ACT_READ_DIRTY) begin
                  rvalid_ff <= 1'b1;
                  cx_ff     <= div_rem_ff[5:0];
                  cy_ff     <= div_num_ff[5:0];
                  state_ff  <= S_FINISH;
               end else begin
                  case (k_ff)
                     2'd0:    nsp_ff.x0 <= CX_W'(clamp_q);
                     2'd1:    nsp_ff.x1 <= CX_W'(clamp_q);
                     2'd2:    nsp_ff.y0 <= CY_W'(clamp_q);
                     default: nsp_ff.y1 <= CY_W'(clamp_q);
                  endcase
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= (k_ff == 2'd3) ? S_DECIDE : S_DIV_LOAD;
               end
            end
            S_LOOKUP: state_ff <= S_DECIDE;
            S_DECIDE: begin
               if (link_pend_ff && !changed) begin
                  state_ff <= S_FINISH;
               end else if (cur_active) begin
                  phase_ff <= PH_DEC;
                  wsp_ff   <= span_rd_ff;
                  state_ff <= S_W_START;
               end else if (link_pend_ff) begin
                  phase_ff            <= PH_LINK;
                  wsp_ff              <= nsp_ff;
                  active_ff[slot_idx] <= 1'b1;
                  state_ff            <= S_W_START;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_W_START: begin
               wx_ff    <= wsp_ff.x0;
               wy_ff    <= wsp_ff.y0;
               state_ff <= span_empty ? S_W_END : S_W_RD;
            end
            S_W_RD: state_ff <= S_W_WR;
            S_W_WR: begin
               if (mark_ok) total_ff <= total_ff + TOT_W'(1);
               state_ff <= S_W_RD;
               if (last_x) begin
                  wx_ff <= wsp_ff.x0;
                  if (last_y) state_ff <= S_W_END;
                  else wy_ff <= wy_ff + CY_W'(1);
               end else begin
                  wx_ff <= wx_ff + CX_W'(1);
               end
            end
            S_W_END: begin
               unique case (phase_ff)
                  PH_DEC: begin
                     phase_ff <= PH_MARK;
                     state_ff <= S_W_START;
                  end
                  PH_MARK: begin
                     active_ff[slot_idx] <= link_pend_ff;
                     if (link_pend_ff) begin
                        phase_ff <= PH_LINK;
                        wsp_ff   <= nsp_ff;
                        state_ff <= S_W_START;
                     end else begin
                        state_ff <= S_FINISH;
                     end
                  end
                  default: state_ff <= S_FINISH;
               endcase
            end
            S_CD_RD: state_ff <= S_CD_WR;
            S_CD_WR: begin
               cd_idx_ff <= cd_idx_ff + CELL_W'(1);
               if (TOT_W'(cd_idx_ff) + TOT_W'(1) == total_ff) begin
                  total_ff <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_CD_RD;
               end
            end
            S_FINISH: begin
               if (rsp_load) begin
                  rsp_status_ff <= status_ff;
                  rsp_active_ff <= slot_ok_ff && cur_active;
                  rsp_rvalid_ff <= rvalid_ff;
                  rsp_cx_ff     <= cx_ff;
                  rsp_cy_ff     <= cy_ff;
                  rsp_count_ff  <= 13'(total_ff);
                  clr_reply_ff  <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready        = state_ff == S_IDLE;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.entry_active = rsp_active_ff;
   assign rsp_chan.read_valid   = rsp_rvalid_ff;
   assign rsp_chan.cell_x       = rsp_cx_ff;
   assign rsp_chan.cell_y       = rsp_cy_ff;
   assign rsp_chan.dirty_count  = rsp_count_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_W'(CELL_CAP))
      else $error("dirty count above capacity");

   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.action == ACT_CLEAR_ALL)
      |=> (total_ff == '0) && (active_ff == '0))
      else $error("clear all left state behind");

   a_link_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W_WR) && (phase_ff == PH_LINK) |-> active_ff[slot_idx])
      else $error("linking an inactive entry");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result loaded outside finish");

endmodule
